// ===== rtl/core/multi_channel_soft_timer_bank_macros.svh =====
// assertion macros for the timer bank
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_MACROS_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_MACROS_SVH

// same-cycle implication, checked outside reset
`define MCTB_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define MCTB_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/mctb_pkg.sv =====
// shared types and constants of the timer bank
package mctb_pkg;

  localparam int CHANNEL_COUNT_DEF = 8;
  localparam int MAX_RESULTS       = 8;
  localparam int CNT_W             = $clog2(MAX_RESULTS + 1);

  localparam logic [2:0] OP_TICK  = 3'd0;
  localparam logic [2:0] OP_SET   = 3'd1;
  localparam logic [2:0] OP_START = 3'd2;
  localparam logic [2:0] OP_STOP  = 3'd3;
  localparam logic [2:0] OP_RESET = 3'd4;
  localparam logic [2:0] OP_ALLOC = 3'd5;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_HANDLE  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;
  localparam logic [1:0] KIND_IDLE    = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic cap;         // capture input beat
    logic tick_start;  // bump tick count, rewind scan
    logic alloc;       // hand out a handle
    logic ack;         // simple op: set / stop / no-op, then ack
    logic rd_ch;       // read entry of addressed channel
    logic rmw;         // write back reload for start / reset
    logic scan_rd;     // read entry of scan index
    logic scan_skip;   // step past idle channel
    logic upd_go;      // decrement, write back, maybe report
    logic fin;         // emit final beat
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] op;
    logic       ch_ok;
    logic       scan_done;
    logic       scan_hit;
    logic       upd_wait;
    logic       out_free;
  } status_t;

endpackage

// ===== rtl/core/mctb_ctrl.sv =====
// sequencing state machine of the timer bank
module mctb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  mctb_pkg::status_t st,
  output mctb_pkg::cmd_t    cmd
);
  import mctb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RMW  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        if (st.op == OP_TICK) begin
          cmd.tick_start = 1'b1;
          state_next     = S_SCAN;
        end else if (st.op == OP_ALLOC) begin
          cmd.alloc  = 1'b1;
          state_next = S_FIN;
        end else if (st.ch_ok && (st.op == OP_START || st.op == OP_RESET)) begin
          cmd.rd_ch  = 1'b1;
          state_next = S_RMW;
        end else begin
          cmd.ack    = 1'b1;
          state_next = S_FIN;
        end
      end
      S_RMW: begin
        cmd.rmw    = 1'b1;
        state_next = S_FIN;
      end
      S_SCAN: begin
        if (st.scan_done) begin
          state_next = S_FIN;
        end else if (st.scan_hit) begin
          cmd.scan_rd = 1'b1;
          state_next  = S_UPD;
        end else begin
          cmd.scan_skip = 1'b1;
        end
      end
      S_UPD: begin
        if (!st.upd_wait) begin
          cmd.upd_go = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.fin    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/mctb_dp.sv =====
// channel store, counters and result register of the timer bank
module mctb_dp #(
  parameter int CHANNEL_COUNT = mctb_pkg::CHANNEL_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  mctb_pkg::cmd_t    cmd,
  output mctb_pkg::status_t st,
  input  logic [2:0]        opcode,
  input  logic [7:0]        channel,
  input  logic [31:0]       load_value,
  input  logic              one_shot,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        kind,
  output logic [15:0]       index_or_handle,
  output logic [31:0]       ticks_seen,
  output logic              last
);
  import mctb_pkg::*;

  localparam int IW = $clog2(CHANNEL_COUNT + 1);
  localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [8:0]  CH_LIM  = 9'(CHANNEL_COUNT);
  localparam logic [IW-1:0] IDX_END = IW'(CHANNEL_COUNT);

  // captured item
  logic [2:0]  op_q;
  logic [7:0]  ch_q;
  logic [31:0] val_q;
  logic        once_q;

  logic [31:0] tick_total;
  logic [15:0] alloc_count;
  logic [CHANNEL_COUNT-1:0] en;
  logic [CHANNEL_COUNT-1:0] os;
  logic [CHANNEL_COUNT-1:0] vld;

  // {reload, down count} per channel
  logic [63:0] mem [CHANNEL_COUNT];
  logic [63:0] rd_q;
  logic        rd_ok_q;

  logic [IW-1:0]    idx;
  logic [CNT_W-1:0] cnt;
  logic             pend_valid;
  logic [1:0]       pend_kind;
  logic [15:0]      pend_idx;

  logic [AW-1:0] ch_a;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] rd_addr;
  logic [15:0]   idx16;
  logic [31:0]   cur_down;
  logic [31:0]   cur_rel;
  logic [31:0]   dec;
  logic          hit;
  logic          report;
  logic          out_free;
  logic          load_mid;

  assign ch_a     = ch_q[AW-1:0];
  assign idx_a    = idx[AW-1:0];
  assign idx16    = {{(16 - IW){1'b0}}, idx};
  assign rd_addr  = cmd.scan_rd ? idx_a : ch_a;
  assign cur_down = rd_ok_q ? rd_q[31:0]  : 32'd0;
  assign cur_rel  = rd_ok_q ? rd_q[63:32] : 32'd0;
  assign dec      = cur_down - 32'd1;
  assign hit      = (dec == 32'd0);
  assign report   = hit && (cnt < CNT_W'(MAX_RESULTS));
  assign out_free = !out_valid || !out_stall;
  assign load_mid = cmd.upd_go && report && pend_valid;

  assign st.op        = op_q;
  assign st.ch_ok     = ({1'b0, ch_q} < CH_LIM);
  assign st.scan_done = (idx == IDX_END);
  assign st.scan_hit  = !st.scan_done && (idx16 < alloc_count) && en[idx_a];
  assign st.upd_wait  = report && pend_valid && !out_free;
  assign st.out_free  = out_free;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_total  <= '0;
      alloc_count <= '0;
      en          <= '0;
      os          <= '0;
      vld         <= '0;
      idx         <= '0;
      cnt         <= '0;
      pend_valid  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.tick_start) begin
        tick_total <= tick_total + 32'd1;
        idx        <= '0;
        cnt        <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.alloc) begin
        alloc_count <= alloc_count + 16'd1;
        pend_valid  <= 1'b1;
      end
      if (cmd.ack) begin
        pend_valid <= 1'b1;
        if (st.ch_ok && op_q == OP_SET) begin
          os[ch_a]  <= once_q;
          vld[ch_a] <= 1'b1;
        end
        if (st.ch_ok && op_q == OP_STOP) begin
          en[ch_a] <= 1'b0;
        end
      end
      if (cmd.rmw) begin
        pend_valid <= 1'b1;
        vld[ch_a]  <= 1'b1;
        en[ch_a]   <= (op_q == OP_START);
      end
      if (cmd.scan_skip) begin
        idx <= idx + IW'(1);
      end
      if (cmd.upd_go) begin
        idx        <= idx + IW'(1);
        vld[idx_a] <= 1'b1;
        if (hit && os[idx_a]) begin
          en[idx_a] <= 1'b0;
        end
        if (report) begin
          pend_valid <= 1'b1;
          cnt        <= cnt + CNT_W'(1);
        end
      end
      if (cmd.fin) begin
        pend_valid <= 1'b0;
      end
      if (load_mid || cmd.fin) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op_q   <= opcode;
      ch_q   <= channel;
      val_q  <= load_value;
      once_q <= one_shot;
    end
    if (cmd.alloc) begin
      pend_kind <= KIND_HANDLE;
      pend_idx  <= alloc_count;
    end
    if (cmd.ack || cmd.rmw) begin
      pend_kind <= KIND_ACK;
      pend_idx  <= 16'd0;
    end
    if (cmd.upd_go && report) begin
      pend_kind <= KIND_EXPIRED;
      pend_idx  <= idx16;
    end
    if (load_mid) begin
      kind            <= pend_kind;
      index_or_handle <= pend_idx;
      ticks_seen      <= tick_total;
      last            <= 1'b0;
    end else if (cmd.fin) begin
      kind            <= pend_valid ? pend_kind : KIND_IDLE;
      index_or_handle <= pend_valid ? pend_idx : 16'd0;
      ticks_seen      <= tick_total;
      last            <= 1'b1;
    end
  end

  // channel store, one read and one write port
  always_ff @(posedge clk) begin
    if (cmd.rd_ch || cmd.scan_rd) begin
      rd_q    <= mem[rd_addr];
      rd_ok_q <= vld[rd_addr];
    end
    if (cmd.ack && st.ch_ok && op_q == OP_SET) begin
      mem[ch_a] <= {val_q, val_q};
    end else if (cmd.rmw) begin
      mem[ch_a] <= {cur_rel, cur_rel};
    end else if (cmd.upd_go) begin
      mem[idx_a] <= {cur_rel, (hit ? cur_rel : dec)};
    end
  end

endmodule

// ===== rtl/core/multi_channel_soft_timer_bank.sv =====
// top level of the timer bank: controller plus channel datapath
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_stall  | opcode, channel, load_value, one_shot
//  out     | out_valid/ out_stall | kind, index_or_handle, ticks_seen, last
//
// a tick walks the channel store entry by entry through its single read
// port, skipping idle channels and updating active ones; an update may wait
// while out is stalled; start/reset of an in-range channel add a reload step
// reset (rst, synchronous) clears all channels, counts and handshake state
// at once; store entries carry valid bits and read as zero until written
// in_stall is high from the accepted beat until its last result is loaded
// into the output register; each expiry is held one step so last is known

`include "multi_channel_soft_timer_bank_macros.svh"

module multi_channel_soft_timer_bank #(
  parameter int CHANNEL_COUNT = mctb_pkg::CHANNEL_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  opcode,
  input  logic [7:0]  channel,
  input  logic [31:0] load_value,
  input  logic        one_shot,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [15:0] index_or_handle,
  output logic [31:0] ticks_seen,
  output logic        last
);
  import mctb_pkg::*;

  cmd_t    cmd;
  status_t st;

  // result beats that never come in trains, and those that carry index zero
  logic one_beat_out;
  logic zero_idx_out;

  assign one_beat_out = out_valid &&
                        (kind == KIND_ACK || kind == KIND_HANDLE || kind == KIND_IDLE);
  assign zero_idx_out = out_valid && (kind == KIND_ACK || kind == KIND_IDLE);

  // sequencer: dispatch, channel scan, result hand-off
  mctb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // channel store, tick and handle counters, output register
  mctb_dp #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .opcode          (opcode),
    .channel         (channel),
    .load_value      (load_value),
    .one_shot        (one_shot),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .kind            (kind),
    .index_or_handle (index_or_handle),
    .ticks_seen      (ticks_seen),
    .last            (last)
  );

  // one item at a time: an accepted beat closes the input
  `MCTB_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")
  // acks, handles and idle ticks are single-beat results
  `MCTB_ASSERT_IMP(a_single_last, one_beat_out, last, "single result without last")
  // acks and idle ticks carry index zero
  `MCTB_ASSERT_IMP(a_ack_zero_idx, zero_idx_out, index_or_handle == 16'd0, "nonzero index on ack")

endmodule
